// ===== hdl/vcrd_pkg.sv =====
`timescale 1ns / 1ps

package vcrd_pkg;

  typedef enum logic [2:0] {
    OP_READ    = 3'd0,
    OP_WRITE   = 3'd1,
    OP_ACQUIRE = 3'd2,
    OP_RELEASE = 3'd3,
    OP_FORK    = 3'd4,
    OP_JOIN    = 3'd5
  } op_e;

  // Datapath steps requested by the controller, at most one step bit per cycle.
  typedef struct packed {
    op_e  op;
    logic clear;
    logic load;
    logic ep0;
    logic ep1;
    logic ep2;
    logic rd_dec;
    logic wr_dec;
    logic sh_wr;
    logic scan_rd;
    logic scan_cmp;
    logic mg_rd1;
    logic mg_rd2;
    logic mg_wr;
    logic rl_rd;
    logic rl_wr;
    logic ad_rd;
    logic ad_wr;
    logic done;
  } dp_cmd_t;

  typedef struct packed {
    logic in_ok;
    logic clr_last;
    logic last;
    logic rd_shclr;
    logic wr_scan;
  } dp_stat_t;

endpackage

// ===== hdl/vector_clock_race_detector.sv =====
`timescale 1ns / 1ps

// Epoch-based data-race detector holding a vector clock per thread and per lock and, per
// variable, a write epoch, a read epoch or shared marker and a read vector clock. Each request
// gives one result with three race flags. After reset a clearing pass writes the initial
// values into every memory, one address per cycle, with an address counter of
// max(2*TW, LW+TW, VW+TW) bits (11 at the default sizes, TW, LW and VW being the index widths
// of threads, locks and variables); no request is taken until it ends. Every clock entry lives
// in single-read-port memories, so a request walks entries one at a time: a read that turns
// shared fills the read vector, a write over shared reads scans it, an acquire, fork or join
// merges a vector clock entry by entry and a release copies the thread clock into the lock
// clock. An out-of-range index or an unknown command goes straight to the result and reports
// no race. A finished result waits in the output register while the next request is accepted.
module vector_clock_race_detector #(
  parameter int THREADS    = 8,
  parameter int VARIABLES  = 256,
  parameter int LOCKS      = 16,
  parameter int CLOCK_BITS = 32
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] cmd_i,
  input  logic [2:0] thread_i,
  input  logic [2:0] other_thread_i,
  input  logic [7:0] variable_i,
  input  logic [3:0] lock_index_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       write_read_race_o,
  output logic       write_write_race_o,
  output logic       read_write_race_o
);
  import vcrd_pkg::*;

  // The controller sequences the steps; the datapath owns the detector state and all memories.
  dp_cmd_t  dcmd;
  dp_stat_t stat;

  vcrd_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .cmd_i,
    .out_valid_o,
    .out_ready_i,
    .stat_i (stat),
    .dcmd_o (dcmd)
  );

  vcrd_dpath #(
    .THREADS    (THREADS),
    .VARIABLES  (VARIABLES),
    .LOCKS      (LOCKS),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_dpath (
    .clk_i,
    .rst_ni,
    .cmd_i,
    .thread_i,
    .other_thread_i,
    .variable_i,
    .lock_index_i,
    .dcmd_i (dcmd),
    .stat_o (stat),
    .write_read_race_o,
    .write_write_race_o,
    .read_write_race_o
  );

endmodule

// ===== hdl/vcrd_ram.sv =====
`timescale 1ns / 1ps

module vcrd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/vcrd_ctrl.sv =====
`timescale 1ns / 1ps

module vcrd_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         cmd_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  vcrd_pkg::dp_stat_t stat_i,
  output vcrd_pkg::dp_cmd_t  dcmd_o
);
  import vcrd_pkg::*;

  typedef enum logic [17:0] {
    S_CLR   = 18'h00001,
    S_IDLE  = 18'h00002,
    S_EP0   = 18'h00004,
    S_EP1   = 18'h00008,
    S_EP2   = 18'h00010,
    S_RDEC  = 18'h00020,
    S_WDEC  = 18'h00040,
    S_SHCLR = 18'h00080,
    S_SCRD  = 18'h00100,
    S_SCCMP = 18'h00200,
    S_MG1   = 18'h00400,
    S_MG2   = 18'h00800,
    S_MGW   = 18'h01000,
    S_RLRD  = 18'h02000,
    S_RLWR  = 18'h04000,
    S_ADRD  = 18'h08000,
    S_ADWR  = 18'h10000,
    S_DONE  = 18'h20000
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign slot_free   = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    out_valid_d = out_valid_q;
    dcmd_o      = '0;
    dcmd_o.op   = op_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_CLR: begin
        dcmd_o.clear = 1'b1;
        if (stat_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          dcmd_o.load = 1'b1;
          op_d        = op_e'(cmd_i);
          if (!stat_i.in_ok) begin
            state_d = S_DONE;
          end else begin
            case (cmd_i)
              OP_READ, OP_WRITE:           state_d = S_EP0;
              OP_ACQUIRE, OP_FORK, OP_JOIN: state_d = S_MG1;
              OP_RELEASE:                  state_d = S_RLRD;
              default:                     state_d = S_DONE;
            endcase
          end
        end
      end
      S_EP0: begin
        dcmd_o.ep0 = 1'b1;
        state_d    = S_EP1;
      end
      S_EP1: begin
        dcmd_o.ep1 = 1'b1;
        state_d    = S_EP2;
      end
      S_EP2: begin
        dcmd_o.ep2 = 1'b1;
        state_d    = (op_q == OP_READ) ? S_RDEC : S_WDEC;
      end
      S_RDEC: begin
        dcmd_o.rd_dec = 1'b1;
        state_d       = stat_i.rd_shclr ? S_SHCLR : S_DONE;
      end
      S_WDEC: begin
        dcmd_o.wr_dec = 1'b1;
        state_d       = stat_i.wr_scan ? S_SCRD : S_DONE;
      end
      S_SHCLR: begin
        dcmd_o.sh_wr = 1'b1;
        if (stat_i.last) begin
          state_d = S_DONE;
        end
      end
      S_SCRD: begin
        dcmd_o.scan_rd = 1'b1;
        state_d        = S_SCCMP;
      end
      S_SCCMP: begin
        dcmd_o.scan_cmp = 1'b1;
        state_d         = stat_i.last ? S_DONE : S_SCRD;
      end
      S_MG1: begin
        dcmd_o.mg_rd1 = 1'b1;
        state_d       = S_MG2;
      end
      S_MG2: begin
        dcmd_o.mg_rd2 = 1'b1;
        state_d       = S_MGW;
      end
      S_MGW: begin
        dcmd_o.mg_wr = 1'b1;
        if (!stat_i.last) begin
          state_d = S_MG1;
        end else begin
          state_d = (op_q == OP_ACQUIRE) ? S_DONE : S_ADRD;
        end
      end
      S_RLRD: begin
        dcmd_o.rl_rd = 1'b1;
        state_d      = S_RLWR;
      end
      S_RLWR: begin
        dcmd_o.rl_wr = 1'b1;
        state_d      = stat_i.last ? S_ADRD : S_RLRD;
      end
      S_ADRD: begin
        dcmd_o.ad_rd = 1'b1;
        state_d      = S_ADWR;
      end
      S_ADWR: begin
        dcmd_o.ad_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          dcmd_o.done = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      op_q        <= OP_READ;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hdl/vcrd_dpath.sv =====
`timescale 1ns / 1ps

module vcrd_dpath #(
  parameter int THREADS    = 8,
  parameter int VARIABLES  = 256,
  parameter int LOCKS      = 16,
  parameter int CLOCK_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [2:0]         cmd_i,
  input  logic [2:0]         thread_i,
  input  logic [2:0]         other_thread_i,
  input  logic [7:0]         variable_i,
  input  logic [3:0]         lock_index_i,
  input  vcrd_pkg::dp_cmd_t  dcmd_i,
  output vcrd_pkg::dp_stat_t stat_o,
  output logic               write_read_race_o,
  output logic               write_write_race_o,
  output logic               read_write_race_o
);
  import vcrd_pkg::*;

  localparam int TW    = $clog2(THREADS);
  localparam int VW    = (VARIABLES > 1) ? $clog2(VARIABLES) : 1;
  localparam int LW    = (LOCKS > 1) ? $clog2(LOCKS) : 1;
  localparam int CB    = CLOCK_BITS;
  localparam int TC_AW = 2 * TW;
  localparam int LC_AW = LW + TW;
  localparam int RV_AW = VW + TW;
  localparam int CW0   = (RV_AW > LC_AW) ? RV_AW : LC_AW;
  localparam int CW    = (CW0 > TC_AW) ? CW0 : TC_AW;
  localparam int WE_W  = CB + TW;
  localparam int RE_W  = CB + TW + 1;

  logic [TW-1:0] t_q, u_q, i_q, r_tid_q, w_tid_q;
  logic [VW-1:0] x_q;
  logic [LW-1:0] l_q;
  logic [CB-1:0] own_q, w_clk_q, r_clk_q, cw_q, va_q;
  logic          r_sh_q;
  logic          fwr_q, fww_q, frw_q;
  logic          owr_q, oww_q, orw_q;
  logic [CW-1:0] clr_q;

  logic             tc_we, tc_re;
  logic [TC_AW-1:0] tc_waddr, tc_raddr;
  logic [CB-1:0]    tc_wdata, tc_rdata;
  logic             lc_we, lc_re;
  logic [LC_AW-1:0] lc_waddr, lc_raddr;
  logic [CB-1:0]    lc_wdata, lc_rdata;
  logic             rv_we, rv_re;
  logic [RV_AW-1:0] rv_waddr, rv_raddr;
  logic [CB-1:0]    rv_wdata, rv_rdata;
  logic             wep_we, rep_we;
  logic [VW-1:0]    ep_waddr;
  logic [WE_W-1:0]  wep_wdata, wep_rdata;
  logic [RE_W-1:0]  rep_wdata, rep_rdata;

  logic [TW-1:0] dst, src, adv;
  logic          rd_same, wr_same, wr_race, r_ordered, step_i;
  logic [CB-1:0] merge_b, sat_inc, sh_val;
  logic          in_ok;

  // Range check straight off the input ports, used on the accepting edge.
  always_comb begin
    case (cmd_i)
      OP_READ, OP_WRITE:     in_ok = (variable_i < VARIABLES);
      OP_ACQUIRE, OP_RELEASE: in_ok = (lock_index_i < LOCKS);
      OP_FORK, OP_JOIN:      in_ok = (other_thread_i < THREADS);
      default:               in_ok = 1'b0;
    endcase
    in_ok = in_ok && (thread_i < THREADS);
  end

  assign dst = (dcmd_i.op == OP_FORK) ? u_q : t_q;
  assign src = (dcmd_i.op == OP_FORK) ? t_q : u_q;
  assign adv = (dcmd_i.op == OP_JOIN) ? u_q : t_q;

  assign rd_same   = !r_sh_q && (r_tid_q == t_q) && (r_clk_q == own_q);
  assign wr_same   = (w_tid_q == t_q) && (w_clk_q == own_q);
  assign wr_race   = (w_clk_q > cw_q);
  assign r_ordered = (r_clk_q <= tc_rdata);
  assign merge_b   = (dcmd_i.op == OP_ACQUIRE) ? lc_rdata : tc_rdata;
  assign sat_inc   = (&tc_rdata) ? tc_rdata : tc_rdata + CB'(1);
  assign step_i    = dcmd_i.sh_wr || dcmd_i.scan_cmp || dcmd_i.mg_wr || dcmd_i.rl_wr;

  // The reader's own clock wins over the earlier reader's epoch.
  always_comb begin
    if (i_q == t_q) begin
      sh_val = own_q;
    end else if (i_q == r_tid_q) begin
      sh_val = r_clk_q;
    end else begin
      sh_val = '0;
    end
  end

  assign stat_o.in_ok    = in_ok;
  assign stat_o.clr_last = &clr_q;
  assign stat_o.last     = (i_q == TW'(THREADS - 1));
  assign stat_o.rd_shclr = !rd_same && !r_sh_q && !r_ordered;
  assign stat_o.wr_scan  = !wr_same && r_sh_q;

  // Thread clock memory ports.
  always_comb begin
    tc_re    = 1'b1;
    tc_raddr = {t_q, t_q};
    if (dcmd_i.ep1) begin
      tc_raddr = {t_q, wep_rdata[WE_W-1:CB]};
    end else if (dcmd_i.ep2) begin
      tc_raddr = {t_q, r_tid_q};
    end else if (dcmd_i.scan_rd || dcmd_i.rl_rd) begin
      tc_raddr = {t_q, i_q};
    end else if (dcmd_i.mg_rd1) begin
      tc_raddr = {dst, i_q};
    end else if (dcmd_i.mg_rd2) begin
      tc_raddr = {src, i_q};
    end else if (dcmd_i.ad_rd) begin
      tc_raddr = {adv, adv};
    end else if (!dcmd_i.ep0) begin
      tc_re = 1'b0;
    end

    tc_we    = 1'b0;
    tc_waddr = {dst, i_q};
    tc_wdata = (va_q > merge_b) ? va_q : merge_b;
    if (dcmd_i.clear) begin
      tc_we    = ((clr_q >> TC_AW) == '0);
      tc_waddr = clr_q[TC_AW-1:0];
      tc_wdata = (clr_q[TC_AW-1:TW] == clr_q[TW-1:0]) ? CB'(1) : '0;
    end else if (dcmd_i.mg_wr) begin
      tc_we = 1'b1;
    end else if (dcmd_i.ad_wr) begin
      tc_we    = 1'b1;
      tc_waddr = {adv, adv};
      tc_wdata = sat_inc;
    end
  end

  // Lock clock memory ports.
  assign lc_re    = dcmd_i.mg_rd1;
  assign lc_raddr = {l_q, i_q};
  assign lc_we    = dcmd_i.clear ? ((clr_q >> LC_AW) == '0) : dcmd_i.rl_wr;
  assign lc_waddr = dcmd_i.clear ? clr_q[LC_AW-1:0] : {l_q, i_q};
  assign lc_wdata = dcmd_i.clear ? '0 : tc_rdata;

  // Read vector memory ports.
  assign rv_re    = dcmd_i.scan_rd;
  assign rv_raddr = {x_q, i_q};
  always_comb begin
    rv_we    = 1'b0;
    rv_waddr = {x_q, i_q};
    rv_wdata = sh_val;
    if (dcmd_i.clear) begin
      rv_we    = ((clr_q >> RV_AW) == '0);
      rv_waddr = clr_q[RV_AW-1:0];
      rv_wdata = '0;
    end else if (dcmd_i.rd_dec) begin
      rv_we    = !rd_same && r_sh_q;
      rv_waddr = {x_q, t_q};
      rv_wdata = own_q;
    end else if (dcmd_i.sh_wr) begin
      rv_we = 1'b1;
    end
  end

  // Epoch memories.
  always_comb begin
    wep_we    = 1'b0;
    rep_we    = 1'b0;
    ep_waddr  = x_q;
    wep_wdata = {t_q, own_q};
    rep_wdata = '0;
    if (dcmd_i.clear) begin
      wep_we    = ((clr_q >> VW) == '0);
      rep_we    = ((clr_q >> VW) == '0);
      ep_waddr  = clr_q[VW-1:0];
      wep_wdata = '0;
    end else if (dcmd_i.rd_dec) begin
      rep_we    = !rd_same && !r_sh_q;
      rep_wdata = r_ordered ? {1'b0, t_q, own_q} : {1'b1, {(TW + CB){1'b0}}};
    end else if (dcmd_i.wr_dec) begin
      wep_we = !wr_same;
      rep_we = !wr_same && r_sh_q;
    end
  end

  vcrd_ram #(.WIDTH(CB), .DEPTH(1 << TC_AW)) u_tc (
    .clk_i, .we_i(tc_we), .waddr_i(tc_waddr), .wdata_i(tc_wdata),
    .re_i(tc_re), .raddr_i(tc_raddr), .rdata_o(tc_rdata)
  );

  vcrd_ram #(.WIDTH(CB), .DEPTH(1 << LC_AW)) u_lc (
    .clk_i, .we_i(lc_we), .waddr_i(lc_waddr), .wdata_i(lc_wdata),
    .re_i(lc_re), .raddr_i(lc_raddr), .rdata_o(lc_rdata)
  );

  vcrd_ram #(.WIDTH(CB), .DEPTH(1 << RV_AW)) u_rv (
    .clk_i, .we_i(rv_we), .waddr_i(rv_waddr), .wdata_i(rv_wdata),
    .re_i(rv_re), .raddr_i(rv_raddr), .rdata_o(rv_rdata)
  );

  vcrd_ram #(.WIDTH(WE_W), .DEPTH(1 << VW)) u_wep (
    .clk_i, .we_i(wep_we), .waddr_i(ep_waddr), .wdata_i(wep_wdata),
    .re_i(dcmd_i.ep0), .raddr_i(x_q), .rdata_o(wep_rdata)
  );

  vcrd_ram #(.WIDTH(RE_W), .DEPTH(1 << VW)) u_rep (
    .clk_i, .we_i(rep_we), .waddr_i(ep_waddr), .wdata_i(rep_wdata),
    .re_i(dcmd_i.ep0), .raddr_i(x_q), .rdata_o(rep_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      i_q   <= '0;
    end else begin
      if (dcmd_i.clear) begin
        clr_q <= clr_q + CW'(1);
      end
      if (dcmd_i.load) begin
        i_q <= '0;
      end else if (step_i) begin
        i_q <= stat_o.last ? '0 : i_q + TW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dcmd_i.load) begin
      t_q   <= TW'(thread_i);
      u_q   <= TW'(other_thread_i);
      x_q   <= VW'(variable_i);
      l_q   <= LW'(lock_index_i);
      fwr_q <= 1'b0;
      fww_q <= 1'b0;
      frw_q <= 1'b0;
    end
    if (dcmd_i.ep1) begin
      own_q   <= tc_rdata;
      w_tid_q <= wep_rdata[WE_W-1:CB];
      w_clk_q <= wep_rdata[CB-1:0];
      r_sh_q  <= rep_rdata[RE_W-1];
      r_tid_q <= rep_rdata[RE_W-2:CB];
      r_clk_q <= rep_rdata[CB-1:0];
    end
    if (dcmd_i.ep2) begin
      cw_q <= tc_rdata;
    end
    if (dcmd_i.mg_rd2) begin
      va_q <= tc_rdata;
    end
    if (dcmd_i.rd_dec && !rd_same) begin
      fwr_q <= wr_race;
    end
    if (dcmd_i.wr_dec && !wr_same) begin
      fww_q <= wr_race;
      frw_q <= !r_sh_q && !r_ordered;
    end
    if (dcmd_i.scan_cmp && (rv_rdata > tc_rdata)) begin
      frw_q <= 1'b1;
    end
    if (dcmd_i.done) begin
      owr_q <= fwr_q;
      oww_q <= fww_q;
      orw_q <= frw_q;
    end
  end

  assign write_read_race_o  = owr_q;
  assign write_write_race_o = oww_q;
  assign read_write_race_o  = orw_q;

endmodule

// ===== hdl/vcrd_checker.sv =====
`timescale 1ns / 1ps

module vcrd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [2:0] cmd_i,
  input logic [2:0] thread_i,
  input logic [2:0] other_thread_i,
  input logic [7:0] variable_i,
  input logic [3:0] lock_index_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       write_read_race_o,
  input logic       write_write_race_o,
  input logic       read_write_race_o
);

  // A stalled result keeps its flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o &&
      $stable({write_read_race_o, write_write_race_o, read_write_race_o}))
    else $error("stalled result changed");

  // A read race never comes together with a write race.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(write_read_race_o && (write_write_race_o || read_write_race_o)))
    else $error("read and write race flags together");

  // One request at a time: ready drops after an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready held after accept");

  // A result appears only after a request has been handled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o || $past(!in_ready_o))
    else $error("result without request");

endmodule

bind vector_clock_race_detector vcrd_checker u_vcrd_checker (.*);
